FILE: design/mwsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer package
// Shared widths, register indexes, reset values and the microcode ROM that
// sequences the shared multiplier datapath.
// ----------------------------------------------------------------------------
package mwsm_pkg;

    localparam int CMD_W    = 16;   // Q4.12 command and target width
    localparam int SMOOTH_W = 24;   // Q4.20 smoothed axis width
    localparam int SPEED_W  = 24;   // Q12.12 wheel speed width
    localparam int CFG_W    = 16;   // widest configuration register
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_W   = 13;
    localparam int DBAND_W  = 12;
    localparam int AGE_W    = 16;

    // Multiplier operand and product widths.
    localparam int MUL_A_W  = 25;
    localparam int MUL_B_W  = 33;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_INV_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0]   RST_INV_RADIUS = 16'd5120;
    localparam logic [CFG_W-1:0]   RST_HALF_BASE  = 16'd2048;
    localparam logic [CFG_W-1:0]   RST_TIMEOUT    = 16'd100;
    localparam logic [GAIN_W-1:0]  RST_GAIN       = 13'd819;
    localparam logic [DBAND_W-1:0] RST_DEADBAND   = 12'd4;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // Tick program step index width.
    localparam int STEP_W = 3;

    typedef enum logic [2:0] {
        A_ZERO,
        A_DIFF_X,
        A_DIFF_Y,
        A_DIFF_Z,
        A_HALF_BASE,
        A_DIFF_LR,
        A_DEAD_Z,
        A_SUM_LR
    } a_sel_t;

    typedef enum logic [1:0] {
        B_GAIN,
        B_RADIUS,
        B_K
    } b_sel_t;

    typedef enum logic [1:0] {
        W_NONE,
        W_X,
        W_Y,
        W_Z
    } wr_sel_t;

    typedef struct packed {
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        wr_sel_t wr_sel;
        logic    ld_k;
        logic    ld_um;
        logic    ld_v;
        logic    ld_out;
        logic    wait_out;
        logic    done;
    } ucode_t;

    // Tick program. The product register always holds the result of the
    // previous step's multiply, so each step consumes what the one before
    // it started.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{a_sel: A_ZERO, b_sel: B_GAIN, wr_sel: W_NONE, ld_k: 1'b0,
              ld_um: 1'b0, ld_v: 1'b0, ld_out: 1'b0, wait_out: 1'b0,
              done: 1'b0};
        unique case (step)
            3'd0: begin
                w.a_sel = A_DIFF_X;
                w.b_sel = B_GAIN;
            end
            3'd1: begin
                w.wr_sel = W_X;
                w.a_sel  = A_DIFF_Y;
                w.b_sel  = B_GAIN;
            end
            3'd2: begin
                w.wr_sel = W_Y;
                w.a_sel  = A_DIFF_Z;
                w.b_sel  = B_GAIN;
            end
            3'd3: begin
                w.wr_sel = W_Z;
                w.a_sel  = A_HALF_BASE;
                w.b_sel  = B_RADIUS;
            end
            3'd4: begin
                w.ld_k  = 1'b1;
                w.a_sel = A_DIFF_LR;
                w.b_sel = B_RADIUS;
            end
            3'd5: begin
                w.ld_um = 1'b1;
                w.a_sel = A_DEAD_Z;
                w.b_sel = B_K;
            end
            3'd6: begin
                w.ld_v  = 1'b1;
                w.a_sel = A_SUM_LR;
                w.b_sel = B_RADIUS;
            end
            3'd7: begin
                w.ld_out   = 1'b1;
                w.wait_out = 1'b1;
                w.done     = 1'b1;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

FILE: design/mwsm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer datapath
// Smoothed axis registers, one shared signed multiplier with a product
// register, and the wheel rounding and saturation stage.
// ----------------------------------------------------------------------------
module mwsm_datapath (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  step_en,
    input  wire mwsm_pkg::ucode_t                      ctrl,
    input  wire logic signed [mwsm_pkg::CMD_W-1:0]     target_x,
    input  wire logic signed [mwsm_pkg::CMD_W-1:0]     target_y,
    input  wire logic signed [mwsm_pkg::CMD_W-1:0]     target_z,
    input  wire logic        [mwsm_pkg::CFG_W-1:0]     inv_radius,
    input  wire logic        [mwsm_pkg::CFG_W-1:0]     half_base,
    input  wire logic        [mwsm_pkg::GAIN_W-1:0]    gain,
    input  wire logic        [mwsm_pkg::DBAND_W-1:0]   deadband,
    output logic signed      [mwsm_pkg::SPEED_W-1:0]   speed_fl,
    output logic signed      [mwsm_pkg::SPEED_W-1:0]   speed_fr,
    output logic signed      [mwsm_pkg::SPEED_W-1:0]   speed_rl,
    output logic signed      [mwsm_pkg::SPEED_W-1:0]   speed_rr
);
    import mwsm_pkg::*;

    localparam int UM_W = 42;   // (lx -/+ ly) * radius
    localparam int V_W  = 57;   // az * half_base * radius
    localparam int K_W  = 32;   // half_base * radius
    localparam int WS_W = 60;   // wheel product before rounding

    logic signed [SMOOTH_W-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [SMOOTH_W-1:0] sx_next, sy_next, sz_next;
    logic signed [MUL_P_W-1:0]  prod_reg;
    logic        [K_W-1:0]      k_reg;
    logic signed [UM_W-1:0]     um_reg;
    logic signed [V_W-1:0]      v_reg;

    logic signed [MUL_A_W-1:0]  a_op;
    logic signed [MUL_B_W-1:0]  b_op;
    logic signed [MUL_P_W-1:0]  mul_res;
    logic signed [SMOOTH_W-1:0] dx, dy, dz;
    logic signed [SMOOTH_W-1:0] smooth_upd;
    logic signed [UM_W-1:0]     up;

    function automatic logic signed [MUL_A_W-1:0] diff(
        input logic signed [CMD_W-1:0]    t,
        input logic signed [SMOOTH_W-1:0] s
    );
        logic signed [MUL_A_W-1:0] tq;
        logic signed [MUL_A_W-1:0] sq;
        tq = {t[CMD_W-1], t, 8'b0};
        sq = {s[SMOOTH_W-1], s};
        return tq - sq;
    endfunction

    function automatic logic signed [SMOOTH_W-1:0] dead(
        input logic signed [SMOOTH_W-1:0] s,
        input logic        [DBAND_W-1:0]  db
    );
        logic [SMOOTH_W-1:0] mag;
        logic [SMOOTH_W-1:0] thr;
        mag = s[SMOOTH_W-1] ? (~s + 1'b1) : s;
        thr = {4'b0, db, 8'b0};
        return (mag < thr) ? '0 : s;
    endfunction

    function automatic logic signed [SPEED_W-1:0] sat24(input logic signed [31:0] x);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        hi = 32'sd8388607;
        lo = -32'sd8388608;
        if (x > hi) begin
            return hi[SPEED_W-1:0];
        end else if (x < lo) begin
            return lo[SPEED_W-1:0];
        end
        return x[SPEED_W-1:0];
    endfunction

    function automatic logic signed [SPEED_W-1:0] wheel(
        input logic signed [UM_W-1:0] u,
        input logic signed [V_W-1:0]  v,
        input logic                   neg
    );
        logic signed [WS_W-1:0] us;
        logic signed [WS_W-1:0] vs;
        logic signed [WS_W-1:0] p;
        us = {{(WS_W-UM_W-12){u[UM_W-1]}}, u, 12'b0};
        vs = {{(WS_W-V_W){v[V_W-1]}}, v};
        p  = neg ? (us - vs) : (us + vs);
        p  = p + (WS_W'(1) <<< 27);
        return sat24(p[59:28]);
    endfunction

    // Deadbanded axes come straight off the smoothed registers.
    assign dx = dead(sx_reg, deadband);
    assign dy = dead(sy_reg, deadband);
    assign dz = dead(sz_reg, deadband);

    always_comb begin
        case (ctrl.a_sel)
            A_DIFF_X:    a_op = diff(target_x, sx_reg);
            A_DIFF_Y:    a_op = diff(target_y, sy_reg);
            A_DIFF_Z:    a_op = diff(target_z, sz_reg);
            A_HALF_BASE: a_op = {9'b0, half_base};
            A_DIFF_LR:   a_op = {dx[SMOOTH_W-1], dx} - {dy[SMOOTH_W-1], dy};
            A_DEAD_Z:    a_op = {dz[SMOOTH_W-1], dz};
            A_SUM_LR:    a_op = {dx[SMOOTH_W-1], dx} + {dy[SMOOTH_W-1], dy};
            default:     a_op = '0;
        endcase
    end

    always_comb begin
        case (ctrl.b_sel)
            B_GAIN:   b_op = {20'b0, gain};
            B_RADIUS: b_op = {17'b0, inv_radius};
            B_K:      b_op = {1'b0, k_reg};
            default:  b_op = '0;
        endcase
    end

    assign mul_res = {{MUL_B_W{a_op[MUL_A_W-1]}}, a_op} *
                     {{MUL_A_W{b_op[MUL_B_W-1]}}, b_op};

    // Smoothing update for whichever axis the product belongs to: the step
    // is the product rounded to nearest (ties up) and shifted down by 12.
    always_comb begin
        logic signed [37:0]         rnd;
        logic signed [26:0]         sum;
        logic signed [SMOOTH_W-1:0] s_old;
        case (ctrl.wr_sel)
            W_Y:     s_old = sy_reg;
            W_Z:     s_old = sz_reg;
            default: s_old = sx_reg;
        endcase
        rnd = prod_reg[37:0] + 38'sd2048;
        sum = {{3{s_old[SMOOTH_W-1]}}, s_old} + {rnd[37], rnd[37:12]};
        if (sum > 27'sd8388607) begin
            smooth_upd = 24'sh7FFFFF;
        end else if (sum < -27'sd8388608) begin
            smooth_upd = 24'sh800000;
        end else begin
            smooth_upd = sum[SMOOTH_W-1:0];
        end
    end

    always_comb begin
        sx_next = sx_reg;
        sy_next = sy_reg;
        sz_next = sz_reg;
        if (step_en) begin
            case (ctrl.wr_sel)
                W_X:     sx_next = smooth_upd;
                W_Y:     sy_next = smooth_upd;
                W_Z:     sz_next = smooth_upd;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
        end else begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sz_reg <= sz_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            prod_reg <= mul_res;
            if (ctrl.ld_k) begin
                k_reg <= prod_reg[K_W-1:0];
            end
            if (ctrl.ld_um) begin
                um_reg <= prod_reg[UM_W-1:0];
            end
            if (ctrl.ld_v) begin
                v_reg <= prod_reg[V_W-1:0];
            end
        end
    end

    // On the last step the product register holds (lx + ly) * radius.
    assign up = prod_reg[UM_W-1:0];

    assign speed_fl = wheel(um_reg, v_reg, 1'b1);
    assign speed_fr = wheel(up,     v_reg, 1'b0);
    assign speed_rl = wheel(up,     v_reg, 1'b1);
    assign speed_rr = wheel(um_reg, v_reg, 1'b0);

endmodule
`default_nettype wire

FILE: design/mecanum_wheel_speed_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer
// Command timeout, per-axis smoothing with deadband, and four-wheel mecanum
// inverse kinematics driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Carries
//  s_*       in         s_valid/s_ready    opcode plus velocity command
//  m_*       out        m_valid/m_ready    four wheel speeds and timeout flag
//  cfg_*     in         cfg_wr_en          register index and write data
//
// A velocity command is absorbed in the cycle it is accepted and produces no
// item. A control tick runs an eight-step program that shares one 25 x 33
// bit multiplier; its item is loaded into the output register on the last
// step, and no further item is taken until the program ends. The input
// side is free again then, even while a result still sits in the output
// register. The last step holds only when that register is full and not
// being drained. Reset is synchronous and active low; the block comes out
// of reset already timed out.
//
module mecanum_wheel_speed_mixer (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // Input items
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic                                    s_opcode,
    input  wire logic signed [mwsm_pkg::CMD_W-1:0]       s_cmd_forward,
    input  wire logic signed [mwsm_pkg::CMD_W-1:0]       s_cmd_sideways,
    input  wire logic signed [mwsm_pkg::CMD_W-1:0]       s_cmd_turn,
    // Result items
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed      [mwsm_pkg::SPEED_W-1:0]     m_front_left_speed,
    output logic signed      [mwsm_pkg::SPEED_W-1:0]     m_front_right_speed,
    output logic signed      [mwsm_pkg::SPEED_W-1:0]     m_rear_left_speed,
    output logic signed      [mwsm_pkg::SPEED_W-1:0]     m_rear_right_speed,
    output logic                                         m_timed_out,
    // Configuration writes
    input  wire logic                                    cfg_wr_en,
    input  wire logic        [mwsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [mwsm_pkg::CFG_W-1:0]       cfg_data
);
    import mwsm_pkg::*;

    localparam logic OP_COMMAND = 1'b0;

    // Configuration registers.
    logic [CFG_W-1:0]   inv_radius_reg;
    logic [CFG_W-1:0]   half_base_reg;
    logic [CFG_W-1:0]   timeout_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [DBAND_W-1:0] deadband_reg;

    // Targets and command age.
    logic signed [CMD_W-1:0] tgt_x_reg, tgt_y_reg, tgt_z_reg;
    logic signed [CMD_W-1:0] tgt_x_next, tgt_y_next, tgt_z_next;
    logic [AGE_W-1:0]        age_reg, age_next;
    logic [AGE_W-1:0]        age_inc;
    logic                    tick_timeout;
    logic                    to_flag_reg;

    // Sequencer.
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            ctrl;
    logic              stall;
    logic              step_en;

    logic in_accept;
    logic is_cmd;

    logic signed [SPEED_W-1:0] speed_fl, speed_fr, speed_rl, speed_rr;
    logic                      out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_radius_reg <= RST_INV_RADIUS;
            half_base_reg  <= RST_HALF_BASE;
            timeout_reg    <= RST_TIMEOUT;
            gain_reg       <= RST_GAIN;
            deadband_reg   <= RST_DEADBAND;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_INV_RADIUS: inv_radius_reg <= cfg_data;
                REG_HALF_BASE:  half_base_reg  <= cfg_data;
                REG_TIMEOUT:    timeout_reg    <= cfg_data;
                REG_GAIN:       gain_reg       <= cfg_data[GAIN_W-1:0];
                REG_DEADBAND:   deadband_reg   <= cfg_data[DBAND_W-1:0];
                default: ;
            endcase
        end
    end

    // The input side only waits while a tick program is running.
    assign s_ready   = !busy_reg;
    assign in_accept = s_valid && s_ready;
    assign is_cmd    = (s_opcode == OP_COMMAND);

    // The age saturates rather than wrapping, and the timeout is judged on
    // the incremented value, so a timeout of all ones can never trip.
    assign age_inc      = (age_reg == AGE_MAX) ? age_reg : age_reg + 1'b1;
    assign tick_timeout = (age_inc > timeout_reg);

    always_comb begin
        tgt_x_next = tgt_x_reg;
        tgt_y_next = tgt_y_reg;
        tgt_z_next = tgt_z_reg;
        age_next   = age_reg;
        if (in_accept) begin
            if (is_cmd) begin
                tgt_x_next = s_cmd_forward;
                tgt_y_next = s_cmd_sideways;
                tgt_z_next = s_cmd_turn;
                age_next   = '0;
            end else begin
                age_next = age_inc;
                if (tick_timeout) begin
                    tgt_x_next = '0;
                    tgt_y_next = '0;
                    tgt_z_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_x_reg <= '0;
            tgt_y_reg <= '0;
            tgt_z_reg <= '0;
            age_reg   <= AGE_MAX;
        end else begin
            tgt_x_reg <= tgt_x_next;
            tgt_y_reg <= tgt_y_next;
            tgt_z_reg <= tgt_z_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && !is_cmd) begin
            to_flag_reg <= tick_timeout;
        end
    end

    // Microcode fetch. A step marked to wait on the output jumps to itself
    // while the previous result has not been taken.
    assign ctrl    = ucode_rom(step_reg);
    assign stall   = ctrl.wait_out && out_valid_reg && !m_ready;
    assign step_en = busy_reg && !stall;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (busy_reg) begin
            if (!stall) begin
                if (ctrl.done) begin
                    busy_next = 1'b0;
                    step_next = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
        end else if (in_accept && !is_cmd) begin
            busy_next = 1'b1;
            step_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    mwsm_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .ctrl       (ctrl),
        .target_x   (tgt_x_reg),
        .target_y   (tgt_y_reg),
        .target_z   (tgt_z_reg),
        .inv_radius (inv_radius_reg),
        .half_base  (half_base_reg),
        .gain       (gain_reg),
        .deadband   (deadband_reg),
        .speed_fl   (speed_fl),
        .speed_fr   (speed_fr),
        .speed_rl   (speed_rl),
        .speed_rr   (speed_rr)
    );

    // Output register: loaded on the final step, drained by m_ready.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (step_en && ctrl.ld_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && ctrl.ld_out) begin
            m_front_left_speed  <= speed_fl;
            m_front_right_speed <= speed_fr;
            m_rear_left_speed   <= speed_rl;
            m_rear_right_speed  <= speed_rr;
            m_timed_out         <= to_flag_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule
`default_nettype wire

FILE: bench/mwsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer checker
// Follows every accepted command and tick, works out the wheel speeds that
// each tick must give, and compares them with the items that leave the block.
// ----------------------------------------------------------------------------
package mwsm_tb_pkg;

    typedef enum logic {
        OP_COMMAND = 1'b0,
        OP_TICK    = 1'b1
    } op_e;

endpackage

module mwsm_checker
    import mwsm_pkg::*;
    import mwsm_tb_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_opcode,
    input  logic signed [CMD_W-1:0]     s_cmd_forward,
    input  logic signed [CMD_W-1:0]     s_cmd_sideways,
    input  logic signed [CMD_W-1:0]     s_cmd_turn,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [SPEED_W-1:0]   m_front_left_speed,
    input  logic signed [SPEED_W-1:0]   m_front_right_speed,
    input  logic signed [SPEED_W-1:0]   m_rear_left_speed,
    input  logic signed [SPEED_W-1:0]   m_rear_right_speed,
    input  logic                        m_timed_out,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    output int                          wheel_sets_due,
    output int                          fail_count
);

    typedef struct packed {
        logic signed [SPEED_W-1:0] fl;
        logic signed [SPEED_W-1:0] fr;
        logic signed [SPEED_W-1:0] rl;
        logic signed [SPEED_W-1:0] rr;
        logic                      timed_out;
    } wheel_set_t;

    localparam int     REPORT_LIMIT = 10;
    localparam longint SPEED_MAX    = (longint'(1) <<< (SPEED_W - 1)) - 1;
    localparam longint SPEED_MIN    = -(longint'(1) <<< (SPEED_W - 1));

    logic [CFG_W-1:0]          inv_radius;
    logic [CFG_W-1:0]          half_base;
    logic [CFG_W-1:0]          timeout_ticks;
    logic [GAIN_W-1:0]         gain;
    logic [DBAND_W-1:0]        dband;

    logic signed [CMD_W-1:0]    tgt_fwd, tgt_side, tgt_turn;
    logic signed [SMOOTH_W-1:0] sm_fwd, sm_side, sm_turn;
    logic [AGE_W-1:0]           cmd_age;

    wheel_set_t wheel_sets[$];

    function automatic logic signed [SPEED_W-1:0] clip24(input longint x);
        if (x > SPEED_MAX) begin
            x = SPEED_MAX;
        end else if (x < SPEED_MIN) begin
            x = SPEED_MIN;
        end
        return x[SPEED_W-1:0];
    endfunction

    // One smoothing step toward the target, rounded half up.
    function automatic logic signed [SMOOTH_W-1:0] ease(
        input logic signed [SMOOTH_W-1:0] cur,
        input logic signed [CMD_W-1:0]    tgt
    );
        longint gap_to_target;
        gap_to_target = longint'(tgt) * 256 - longint'(cur);
        return clip24(longint'(cur) + ((gap_to_target * longint'(gain) + 2048) >>> 12));
    endfunction

    function automatic longint above_deadband(input logic signed [SMOOTH_W-1:0] v);
        longint mag;
        mag = (v < 0) ? -longint'(v) : longint'(v);
        return (mag < longint'(dband) * 256) ? 0 : longint'(v);
    endfunction

    // Sum is Q.32; times the Q8.8 radius gives Q.40, rounded to nearest to Q12.12.
    function automatic logic signed [SPEED_W-1:0] wheel_speed(input longint sum);
        return clip24((sum * longint'(inv_radius) + (longint'(1) <<< 27)) >>> 28);
    endfunction

    function automatic wheel_set_t run_tick();
        longint     lx, ly, az, a, b, t;
        wheel_set_t w;
        if (cmd_age != AGE_MAX) begin
            cmd_age = cmd_age + 1'b1;
        end
        w.timed_out = (cmd_age > timeout_ticks);
        if (w.timed_out) begin
            tgt_fwd  = '0;
            tgt_side = '0;
            tgt_turn = '0;
        end
        sm_fwd  = ease(sm_fwd, tgt_fwd);
        sm_side = ease(sm_side, tgt_side);
        sm_turn = ease(sm_turn, tgt_turn);
        lx = above_deadband(sm_fwd);
        ly = above_deadband(sm_side);
        az = above_deadband(sm_turn);
        a = lx * 4096;
        b = ly * 4096;
        t = az * longint'(half_base);
        w.fl = wheel_speed(a - b - t);
        w.fr = wheel_speed(a + b + t);
        w.rl = wheel_speed(a + b - t);
        w.rr = wheel_speed(a - b + t);
        return w;
    endfunction

    always @(posedge aclk) begin
        wheel_set_t got, want;
        if (!aresetn) begin
            inv_radius    = RST_INV_RADIUS;
            half_base     = RST_HALF_BASE;
            timeout_ticks = RST_TIMEOUT;
            gain          = RST_GAIN;
            dband         = RST_DEADBAND;
            tgt_fwd       = '0;
            tgt_side      = '0;
            tgt_turn      = '0;
            sm_fwd        = '0;
            sm_side       = '0;
            sm_turn       = '0;
            cmd_age       = AGE_MAX;
            wheel_sets.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_front_left_speed, m_front_right_speed, m_rear_left_speed,
                       m_rear_right_speed, m_timed_out};
                if (wheel_sets.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected item fl=%0d fr=%0d rl=%0d rr=%0d to=%0b",
                                 $realtime, got.fl, got.fr, got.rl, got.rr, got.timed_out);
                    end
                end else begin
                    want = wheel_sets.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: mismatch expected fl=%0d fr=%0d rl=%0d rr=%0d to=%0b",
                                     $realtime, want.fl, want.fr, want.rl, want.rr,
                                     want.timed_out);
                            $display("%0t:          actual   fl=%0d fr=%0d rl=%0d rr=%0d to=%0b",
                                     $realtime, got.fl, got.fr, got.rl, got.rr,
                                     got.timed_out);
                        end
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_INV_RADIUS: inv_radius    = cfg_data;
                    REG_HALF_BASE:  half_base     = cfg_data;
                    REG_TIMEOUT:    timeout_ticks = cfg_data;
                    REG_GAIN:       gain          = cfg_data[GAIN_W-1:0];
                    REG_DEADBAND:   dband         = cfg_data[DBAND_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_opcode == OP_TICK) begin
                    want = run_tick();
                    wheel_sets.insert(wheel_sets.size(), want);
                end else begin
                    tgt_fwd  = s_cmd_forward;
                    tgt_side = s_cmd_sideways;
                    tgt_turn = s_cmd_turn;
                    cmd_age  = '0;
                end
            end
        end
        wheel_sets_due = wheel_sets.size();
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer testbench
// Drives commands and control ticks through the mixer under a series of
// register settings, with random idling on both channels, and leaves the
// checking of every wheel speed item to the checker beside the block.
// ----------------------------------------------------------------------------
module tb;
    import mwsm_pkg::*;
    import mwsm_tb_pkg::*;

    // The slowest run is about 2000 items plus the drains between phases;
    // the limit leaves a wide margin above that.
    localparam int LIMIT_CYCLES  = 400000;
    // Covers any work left in flight once the last item has come out.
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 320;

    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic                      s_opcode       = OP_COMMAND;
    logic signed [CMD_W-1:0]   s_cmd_forward  = '0;
    logic signed [CMD_W-1:0]   s_cmd_sideways = '0;
    logic signed [CMD_W-1:0]   s_cmd_turn     = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic signed [SPEED_W-1:0] m_front_left_speed;
    logic signed [SPEED_W-1:0] m_front_right_speed;
    logic signed [SPEED_W-1:0] m_rear_left_speed;
    logic signed [SPEED_W-1:0] m_rear_right_speed;
    logic                      m_timed_out;
    logic                      cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index      = '0;
    logic [CFG_W-1:0]          cfg_data       = '0;

    int wheel_sets_due;
    int fail_count;

    // Idling controls. The sender and the receiver each go through calm
    // stretches with no idling at all; quiet switches idling off for good.
    bit quiet        = 1'b0;
    int gap_pct      = 0;
    int stall_pct    = 0;
    int items_sent   = 0;
    bit sender_calm  = 1'b0;
    int sender_left  = 0;
    bit sink_calm    = 1'b0;
    int sink_left    = 0;
    int stall_hold   = 0;

    mecanum_wheel_speed_mixer dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_cmd_forward       (s_cmd_forward),
        .s_cmd_sideways      (s_cmd_sideways),
        .s_cmd_turn          (s_cmd_turn),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_front_left_speed  (m_front_left_speed),
        .m_front_right_speed (m_front_right_speed),
        .m_rear_left_speed   (m_rear_left_speed),
        .m_rear_right_speed  (m_rear_right_speed),
        .m_timed_out         (m_timed_out),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    mwsm_checker wheel_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_cmd_forward       (s_cmd_forward),
        .s_cmd_sideways      (s_cmd_sideways),
        .s_cmd_turn          (s_cmd_turn),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_front_left_speed  (m_front_left_speed),
        .m_front_right_speed (m_front_right_speed),
        .m_rear_left_speed   (m_rear_left_speed),
        .m_rear_right_speed  (m_rear_right_speed),
        .m_timed_out         (m_timed_out),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .wheel_sets_due      (wheel_sets_due),
        .fail_count          (fail_count)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost item ends the run here.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side back-pressure comes in bursts; because the bursts start at
    // random, they land on every step of the tick program, including the one
    // that holds a full output.
    always @(negedge aclk) begin
        if (sink_left == 0) begin
            sink_calm = ($urandom_range(2) == 0);
            sink_left = $urandom_range(50, 250);
        end else begin
            sink_left--;
        end
        if (quiet || sink_calm) begin
            stall_hold = 0;
            m_ready    = 1'b1;
        end else if (stall_hold > 0) begin
            stall_hold--;
            m_ready = 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_hold = $urandom_range(0, 6);
            m_ready    = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    function automatic logic [CMD_W-1:0] rnd16();
        return CMD_W'($urandom_range(0, 65535));
    endfunction

    // Velocity values: half full random, with a share near zero so the
    // deadband matters, full scale, and moderate speeds.
    function automatic logic [CMD_W-1:0] pick_speed();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                return rnd16();
            end
            5, 6: begin
                v = $urandom_range(0, 64);
                if ($urandom_range(1) == 1) begin
                    v = -v;
                end
                return CMD_W'(v);
            end
            7: begin
                case ($urandom_range(0, 3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            default: begin
                v = $urandom_range(0, 16384) - 8192;
                return CMD_W'(v);
            end
        endcase
    endfunction

    // Holds one item on the input channel until it is taken. The caller is
    // always at a falling edge, and valid is only dropped for an idle burst,
    // so back-to-back items keep valid high without a dip.
    task automatic send_item(input op_e op, input logic [CMD_W-1:0] fwd,
                             input logic [CMD_W-1:0] side, input logic [CMD_W-1:0] turn);
        s_valid        = 1'b1;
        s_opcode       = op;
        s_cmd_forward  = fwd;
        s_cmd_sideways = side;
        s_cmd_turn     = turn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        if (sender_left == 0) begin
            sender_calm = ($urandom_range(2) == 0);
            sender_left = $urandom_range(20, 80);
        end else begin
            sender_left--;
        end
        if (!quiet && !sender_calm && $urandom_range(99) < gap_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
    endtask

    // Stops sending and waits until every tick has produced its item, then
    // lets the block finish anything still in flight.
    task automatic settle();
        s_valid = 1'b0;
        while (wheel_sets_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic load_config(input logic [CFG_W-1:0] inv, input logic [CFG_W-1:0] half,
                               input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] gain,
                               input logic [CFG_W-1:0] dband);
        write_reg(REG_INV_RADIUS, inv);
        write_reg(REG_HALF_BASE, half);
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_GAIN, gain);
        write_reg(REG_DEADBAND, dband);
    endtask

    // The usual shape of traffic: a command followed by a run of ticks.
    // Now and then the run is long enough to cross the timeout.
    task automatic command_then_ticks(input int tmo_hint);
        int run;
        if ($urandom_range(99) < 85) begin
            send_item(OP_COMMAND, pick_speed(), pick_speed(), pick_speed());
        end
        if ($urandom_range(9) == 0) begin
            run = $urandom_range(1, tmo_hint + 4);
        end else begin
            run = $urandom_range(1, 12);
        end
        repeat (run) send_item(OP_TICK, rnd16(), rnd16(), rnd16());
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] inv, input logic [CFG_W-1:0] half,
                             input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] gain,
                             input logic [CFG_W-1:0] dband, input int gap, input int stall);
        int stop_at;
        int hint;
        settle();
        load_config(inv, half, tmo, gain, dband);
        gap_pct   = gap;
        stall_pct = stall;
        hint      = (tmo > 120) ? 120 : int'(tmo);
        stop_at   = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) == 0) begin
                // The sender holds off until every result is home.
                settle();
            end else if ($urandom_range(19) == 0) begin
                // Stray item: either opcode, fully random fields.
                send_item(op_e'($urandom_range(1)), rnd16(), rnd16(), rnd16());
            end else begin
                command_then_ticks(hint);
            end
        end
    endtask

    initial begin
        // Synchronous reset, released on a falling edge.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part with the reset register values and no idling.
        // Straight out of reset the block has never had a command, so the
        // first tick is already timed out.
        send_item(OP_TICK, '0, '0, '0);
        settle();
        // The age counter sits at its top value; with the largest timeout
        // that still allows timing out, a wrapped counter would show here.
        write_reg(REG_TIMEOUT, 16'd65534);
        send_item(OP_TICK, '1, '1, '1);
        settle();
        write_reg(REG_TIMEOUT, RST_TIMEOUT);

        // Full positive scale on every axis.
        send_item(OP_COMMAND, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        repeat (3) send_item(OP_TICK, '0, '0, '0);
        // Full negative scale on every axis.
        send_item(OP_COMMAND, 16'h8000, 16'h8000, 16'h8000);
        repeat (2) send_item(OP_TICK, '1, '1, '1);
        // Opposite extremes with no turn.
        send_item(OP_COMMAND, 16'h7FFF, 16'h8000, 16'h0000);
        send_item(OP_TICK, '0, '0, '0);
        // Tiny command that lies inside the deadband.
        send_item(OP_COMMAND, 16'h0001, 16'hFFFF, 16'h0002);
        repeat (2) send_item(OP_TICK, '0, '0, '0);
        // A second command replaces the first before any tick.
        send_item(OP_COMMAND, 16'h1000, 16'h1000, 16'h1000);
        send_item(OP_COMMAND, 16'hF000, 16'h0800, 16'hFC00);
        send_item(OP_TICK, '0, '0, '0);
        settle();
        // Timeout of one tick: the first tick is fresh, the second is not.
        write_reg(REG_TIMEOUT, 16'd1);
        send_item(OP_COMMAND, 16'h2000, 16'hE000, 16'h0400);
        repeat (2) send_item(OP_TICK, '0, '0, '0);

        // Random phases, each under its own register setting.
        run_phase(16'd5120, 16'd2048, 16'd20, 16'd819, 16'd4, 25, 25);
        // Top of every register: gain above unity overshoots, the timeout
        // can never be exceeded, and the outputs saturate.
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1FFF, 16'h0FFF, 15, 40);
        // Bottom of every register: the smoothed values never move, every tick times out.
        run_phase(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 30, 10);
        // Unity gain follows the target in one step.
        run_phase(16'd256, 16'd4096, 16'd3, 16'd4096, 16'd0, 10, 30);
        // Random settings; gain and deadband data carry junk above their
        // width, which the block must drop.
        run_phase(rnd16(), rnd16(), CFG_W'($urandom_range(0, 40)), rnd16(), rnd16(), 40, 40);

        // Writes to indexes past the last register must change nothing.
        settle();
        for (int i = int'(REG_DEADBAND) + 1; i < (1 << CFG_IDX_W); i++) begin
            write_reg(CFG_IDX_W'(i), rnd16());
        end

        // Last part runs at full rate on both sides.
        quiet = 1'b1;
        run_phase(16'd1024, 16'd1024, 16'd50, 16'd2048, 16'd16, 0, 0);

        settle();
        if (fail_count == 0 && wheel_sets_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: mecanum_wheel_speed_mixer.f
design/mwsm_pkg.sv
design/mwsm_datapath.sv
design/mecanum_wheel_speed_mixer.sv
bench/mwsm_checker.sv
bench/tb.sv
